/* hw/rtl/crfn_pkg.sv */
// Shared types, result codes and chord interval tables for the four-note chord recognizer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package crfn_pkg;

    // Result kinds.
    localparam logic [2:0] KIND_NONE     = 3'd0;
    localparam logic [2:0] KIND_NOTE     = 3'd1;
    localparam logic [2:0] KIND_INTERVAL = 3'd2;
    localparam logic [2:0] KIND_TRIAD    = 3'd3;
    localparam logic [2:0] KIND_CHORD    = 3'd4;

    localparam int OCTAVE = 12;
    localparam int TRIAD_COUNT = 6;
    localparam int CHORD_COUNT = 9;

    // Intervals above the root, in semitones.
    localparam int TRIAD_TAB [TRIAD_COUNT][2] = '{
        '{4, 7}, '{4, 8}, '{3, 7}, '{3, 6}, '{2, 7}, '{5, 7}
    };
    localparam int CHORD_TAB [CHORD_COUNT][3] = '{
        '{4, 7, 9}, '{4, 7, 10}, '{4, 7, 11}, '{4, 8, 10}, '{3, 7, 9},
        '{3, 7, 10}, '{3, 7, 11}, '{3, 6, 9}, '{3, 6, 10}
    };

    // Sorted note set, as differences from the lowest notes plus pitch classes.
    typedef struct packed {
        logic [2:0]      count;
        logic [8:0]      d1;     // p1 - p0
        logic [8:0]      d2;     // p2 - p0
        logic [8:0]      d3;     // p3 - p0
        logic [8:0]      e1;     // p2 - p1
        logic [8:0]      e2;     // p3 - p1
        logic [3:0][3:0] pc;     // pitch class of each sorted note
    } notes_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] root_class;
        logic [3:0] quality;
        logic       has_bass;
        logic [3:0] bass_class;
    } result_t;

endpackage

/* hw/rtl/crfn_classify.sv */
// Chord table matching and result selection for one sorted note set.
// Depends on crfn_pkg for the tables, the result codes and the stage types.
`timescale 1ns / 1ps

module crfn_classify import crfn_pkg::*; (
    input  notes_t  notes,
    output result_t result
);

    typedef struct packed {
        logic       hit;
        logic [2:0] kind;
        logic [1:0] root_sel;
        logic [1:0] bass_sel;
        logic [3:0] qual;
        logic       inv;
    } match_t;

    // Triad on three consecutive sorted notes starting at index base, with the
    // interval fallback when the outer or upper pair spans whole octaves.
    function automatic match_t triad_eval(input logic [8:0] i1, input logic [8:0] i2,
                                          input logic m_outer, input logic m_upper,
                                          input logic [1:0] base);
        match_t r;
        r = '0;
        for (int t = 0; t < TRIAD_COUNT; t++) begin
            if (!r.hit && i1 == 9'(TRIAD_TAB[t][0]) && i2 == 9'(TRIAD_TAB[t][1])) begin
                r = '{1'b1, KIND_TRIAD, base, base, 4'(t), 1'b0};
            end
        end
        for (int t = 0; t < TRIAD_COUNT; t++) begin
            if (!r.hit && i1 == 9'(OCTAVE - TRIAD_TAB[t][1])
                    && i2 == 9'(TRIAD_TAB[t][0] + OCTAVE - TRIAD_TAB[t][1])) begin
                r = '{1'b1, KIND_TRIAD, 2'(base + 2'd1), base, 4'(t), 1'b1};
            end
        end
        for (int t = 0; t < TRIAD_COUNT; t++) begin
            if (!r.hit && i1 == 9'(TRIAD_TAB[t][1] - TRIAD_TAB[t][0])
                    && i2 == 9'(OCTAVE - TRIAD_TAB[t][0])) begin
                r = '{1'b1, KIND_TRIAD, 2'(base + 2'd2), base, 4'(t), 1'b1};
            end
        end
        if (!r.hit && (m_outer || m_upper) && i1 <= 9'(OCTAVE)) begin
            r = '{1'b1, KIND_INTERVAL, base, base, i1[3:0], 1'b0};
        end
        return r;
    endfunction

    // Four-note chord in root position and its three inversions.
    function automatic match_t chord_eval(input logic [8:0] i1, input logic [8:0] i2,
                                          input logic [8:0] i3);
        match_t r;
        r = '0;
        for (int c = 0; c < CHORD_COUNT; c++) begin
            if (!r.hit && i1 == 9'(CHORD_TAB[c][0]) && i2 == 9'(CHORD_TAB[c][1])
                    && i3 == 9'(CHORD_TAB[c][2])) begin
                r = '{1'b1, KIND_CHORD, 2'd0, 2'd0, 4'(c), 1'b0};
            end
        end
        for (int c = 0; c < CHORD_COUNT; c++) begin
            if (!r.hit && i1 == 9'(OCTAVE - CHORD_TAB[c][2])
                    && i2 == 9'(CHORD_TAB[c][0] + OCTAVE - CHORD_TAB[c][2])
                    && i3 == 9'(CHORD_TAB[c][1] + OCTAVE - CHORD_TAB[c][2])) begin
                r = '{1'b1, KIND_CHORD, 2'd1, 2'd0, 4'(c), 1'b1};
            end
        end
        for (int c = 0; c < CHORD_COUNT; c++) begin
            if (!r.hit && i1 == 9'(CHORD_TAB[c][2] - CHORD_TAB[c][1])
                    && i2 == 9'(OCTAVE - CHORD_TAB[c][1])
                    && i3 == 9'(CHORD_TAB[c][0] + OCTAVE - CHORD_TAB[c][1])) begin
                r = '{1'b1, KIND_CHORD, 2'd2, 2'd0, 4'(c), 1'b1};
            end
        end
        for (int c = 0; c < CHORD_COUNT; c++) begin
            if (!r.hit && i1 == 9'(CHORD_TAB[c][1] - CHORD_TAB[c][0])
                    && i2 == 9'(CHORD_TAB[c][2] - CHORD_TAB[c][0])
                    && i3 == 9'(OCTAVE - CHORD_TAB[c][0])) begin
                r = '{1'b1, KIND_CHORD, 2'd3, 2'd0, 4'(c), 1'b1};
            end
        end
        return r;
    endfunction

    match_t m_low;
    match_t m_up;
    match_t m_four;
    match_t m_sel;

    // Equal pitch classes mean the two notes lie whole octaves apart.
    assign m_low  = triad_eval(notes.d1, notes.d2, notes.pc[0] == notes.pc[2],
                               notes.pc[1] == notes.pc[2], 2'd0);
    assign m_up   = triad_eval(notes.e1, notes.e2, notes.pc[1] == notes.pc[3],
                               notes.pc[2] == notes.pc[3], 2'd1);
    assign m_four = chord_eval(notes.d1, notes.d2, notes.d3);

    always_comb begin
        m_sel = '0;
        case (notes.count)
            3'd1: begin
                m_sel = '{1'b1, KIND_NOTE, 2'd0, 2'd0, 4'd0, 1'b0};
            end
            3'd2: begin
                if (notes.d1 <= 9'(OCTAVE)) begin
                    m_sel = '{1'b1, KIND_INTERVAL, 2'd0, 2'd0, notes.d1[3:0], 1'b0};
                end
            end
            3'd3: begin
                m_sel = m_low;
            end
            3'd4: begin
                if (m_four.hit) begin
                    m_sel = m_four;
                end else if (notes.pc[0] == notes.pc[1] && m_up.hit) begin
                    m_sel = m_up;
                end else if (notes.pc[0] == notes.pc[3] && m_low.hit) begin
                    m_sel = m_low;
                end else if (notes.pc[0] == notes.pc[2] && notes.pc[1] == notes.pc[3]
                        && notes.d1 <= 9'(OCTAVE)) begin
                    m_sel = '{1'b1, KIND_INTERVAL, 2'd0, 2'd0, notes.d1[3:0], 1'b0};
                end
            end
            default: begin
                m_sel = '0;
            end
        endcase
    end

    always_comb begin
        result = '0;
        if (m_sel.hit) begin
            result.kind       = m_sel.kind;
            result.root_class = notes.pc[m_sel.root_sel];
            result.quality    = m_sel.qual;
            result.has_bass   = m_sel.inv;
            result.bass_class = m_sel.inv ? notes.pc[m_sel.bass_sel] : 4'd0;
        end
    end

endmodule

/* hw/rtl/chord_recognizer_four_note.sv */
// Four-note chord recognizer: an accepted input transaction passes through the register stages
// to its result on the output registers; one transaction is accepted every cycle while m_ready does not stall it.
// The four register stages are semitone rounding, dedup and sort, interval and pitch class
// extraction, and table matching into the output register; each stalls only when full.
// Reset (aresetn low, synchronous) empties all stages; payload registers are not reset.
`timescale 1ns / 1ps

module chord_recognizer_four_note import crfn_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [14:0] s_cv_a,
    input  logic signed [14:0] s_cv_b,
    input  logic signed [14:0] s_cv_c,
    input  logic signed [14:0] s_cv_d,
    input  logic               s_valid_a,
    input  logic               s_valid_b,
    input  logic               s_valid_c,
    input  logic               s_valid_d,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_kind,
    output logic [3:0]         m_root_class,
    output logic [3:0]         m_quality,
    output logic               m_has_bass,
    output logic [3:0]         m_bass_class
);

    // Semitones are carried with an offset of 192 (sixteen octaves), so every
    // note of the input range is a nonnegative 9-bit value and its pitch class
    // is unchanged.
    localparam logic [8:0] SEMI_OFFSET = 9'd192;

    // Rounds volts * 1024 times 12 to the nearest semitone, halves away from zero.
    function automatic logic [8:0] to_semi(input logic signed [14:0] x);
        logic signed [18:0] xe;
        logic signed [18:0] n;
        logic [17:0]        m;
        logic [18:0]        r;
        logic [7:0]         q;
        xe = {{4{x[14]}}, x};
        n  = (xe <<< 3) + (xe <<< 2);
        m  = n[18] ? 18'(-n) : n[17:0];
        r  = {1'b0, m} + 19'd512;
        q  = r[17:10];
        return n[18] ? SEMI_OFFSET - {1'b0, q} : SEMI_OFFSET + {1'b0, q};
    endfunction

    // Value modulo 12 through a reciprocal estimate and one correction step.
    function automatic logic [3:0] pclass(input logic [8:0] u);
        logic [14:0] prod;
        logic [5:0]  q;
        logic [10:0] t;
        prod = 15'(u) * 15'd43;
        q    = prod[14:9];
        t    = {2'b00, u} - 11'({q, 3'b000}) - 11'({q, 2'b00});
        if (t[10]) begin
            t = t + 11'd12;
        end
        return t[3:0];
    endfunction

    // Stage enables: a stage loads when it is empty or its contents move on.
    logic en1, en2, en3, en4;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;

    assign en4 = !v4_reg || m_ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_ready = en1;

    assign v1_next = en1 ? s_valid : v1_reg;
    assign v2_next = en2 ? v1_reg  : v2_reg;
    assign v3_next = en3 ? v2_reg  : v3_reg;
    assign v4_next = en4 ? v3_reg  : v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // Stage 1: each voltage rounded to an offset semitone, with its presence flag.
    logic [3:0][8:0] semi_reg;
    logic [3:0]      pres_reg;

    always_ff @(posedge aclk) begin
        if (en1 && s_valid) begin
            semi_reg <= {to_semi(s_cv_d), to_semi(s_cv_c), to_semi(s_cv_b), to_semi(s_cv_a)};
            pres_reg <= {s_valid_d, s_valid_c, s_valid_b, s_valid_a};
        end
    end

    // Stage 2: a note repeating an earlier present note is dropped. The kept
    // notes go through a five-comparator sorting network; a dropped note gets
    // its top key bit set so that it sorts above every kept note.
    logic [3:0]       keep;
    logic [3:0][9:0]  key0, key1, key2;
    logic [2:0]       count_next;
    logic [3:0][8:0]  sorted_reg;
    logic [2:0]       count_reg;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            keep[i] = pres_reg[i];
            for (int j = 0; j < i; j++) begin
                if (pres_reg[j] && semi_reg[j] == semi_reg[i]) begin
                    keep[i] = 1'b0;
                end
            end
            key0[i] = {!keep[i], semi_reg[i]};
        end
        count_next = 3'(keep[0]) + 3'(keep[1]) + 3'(keep[2]) + 3'(keep[3]);

        key1 = key0;
        if (key0[0] > key0[1]) begin
            key1[0] = key0[1];
            key1[1] = key0[0];
        end
        if (key0[2] > key0[3]) begin
            key1[2] = key0[3];
            key1[3] = key0[2];
        end

        key2 = key1;
        if (key1[0] > key1[2]) begin
            key2[0] = key1[2];
            key2[2] = key1[0];
        end
        if (key1[1] > key1[3]) begin
            key2[1] = key1[3];
            key2[3] = key1[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en2 && v1_reg) begin
            sorted_reg[0] <= key2[0][8:0];
            sorted_reg[3] <= key2[3][8:0];
            if (key2[1] > key2[2]) begin
                sorted_reg[1] <= key2[2][8:0];
                sorted_reg[2] <= key2[1][8:0];
            end else begin
                sorted_reg[1] <= key2[1][8:0];
                sorted_reg[2] <= key2[2][8:0];
            end
            count_reg <= count_next;
        end
    end

    // Stage 3: intervals above the lowest and second-lowest notes, and pitch
    // classes. Entries past the note count hold don't-care values.
    notes_t notes_next;
    notes_t notes_reg;

    always_comb begin
        notes_next.count = count_reg;
        notes_next.d1    = sorted_reg[1] - sorted_reg[0];
        notes_next.d2    = sorted_reg[2] - sorted_reg[0];
        notes_next.d3    = sorted_reg[3] - sorted_reg[0];
        notes_next.e1    = sorted_reg[2] - sorted_reg[1];
        notes_next.e2    = sorted_reg[3] - sorted_reg[1];
        for (int i = 0; i < 4; i++) begin
            notes_next.pc[i] = pclass(sorted_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en3 && v2_reg) begin
            notes_reg <= notes_next;
        end
    end

    // Stage 4: table matching with inversions and octave fallbacks, registered
    // straight into the output transaction.
    result_t res_next;
    result_t res_reg;

    crfn_classify u_classify (
        .notes  (notes_reg),
        .result (res_next)
    );

    always_ff @(posedge aclk) begin
        if (en4 && v3_reg) begin
            res_reg <= res_next;
        end
    end

    assign m_valid      = v4_reg;
    assign m_kind       = res_reg.kind;
    assign m_root_class = res_reg.root_class;
    assign m_quality    = res_reg.quality;
    assign m_has_bass   = res_reg.has_bass;
    assign m_bass_class = res_reg.bass_class;

endmodule

/* hw/rtl/crfn_checker.sv */
// Port-level checks on the result transactions of the four-note chord recognizer.
// Depends on crfn_pkg for the result kinds; bound to chord_recognizer_four_note below.
`timescale 1ns / 1ps

module crfn_checker import crfn_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_kind,
    input logic [3:0] m_root_class,
    input logic [3:0] m_quality,
    input logic       m_has_bass,
    input logic [3:0] m_bass_class
);

    // A stalled result transaction stays and keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_root_class)
            && $stable(m_quality) && $stable(m_has_bass) && $stable(m_bass_class))
        else $error("result transaction changed while stalled");

    // No match or no notes clears every other field.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_NONE |-> m_root_class == 4'd0 && m_quality == 4'd0
            && !m_has_bass && m_bass_class == 4'd0)
        else $error("empty result carries nonzero fields");

    // A slash bass note only comes from a triad or four-note inversion.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_has_bass |-> m_kind == KIND_TRIAD || m_kind == KIND_CHORD)
        else $error("bass note on a result that is not a chord");

    // Pitch classes stay below an octave, and bass is zero without an inversion.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_root_class < 4'd12 && m_bass_class < 4'd12
            && (m_has_bass || m_bass_class == 4'd0))
        else $error("pitch class out of range");

    // Table indexes fit their tables.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_kind != KIND_TRIAD || m_quality < 4'(TRIAD_COUNT))
            && (m_kind != KIND_CHORD || m_quality < 4'(CHORD_COUNT))
            && (m_kind != KIND_INTERVAL || m_quality <= 4'(OCTAVE)))
        else $error("quality outside its table");

endmodule

bind chord_recognizer_four_note crfn_checker u_crfn_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_kind       (m_kind),
    .m_root_class (m_root_class),
    .m_quality    (m_quality),
    .m_has_bass   (m_has_bass),
    .m_bass_class (m_bass_class)
);
